### design/dabpr_pkg.sv
package dabpr_pkg;

  localparam logic [1:0] MODE_I  = 2'd0;
  localparam logic [1:0] MODE_II = 2'd1;
  localparam logic [1:0] MODE_IV = 2'd2;

  // half widths per mode and the band width
  localparam int HALF_M1 = 768;
  localparam int HALF_M2 = 192;
  localparam int HALF_M4 = 384;
  localparam int BAND_W  = 32;

  // band entry: row i in [3:2], offset n in [1:0], lowest k first
  localparam logic [3:0] BANDS_M1 [48] = '{
    4'h1, 4'h6, 4'h8, 4'hD, 4'h3, 4'h6, 4'hA, 4'hF, 4'h2, 4'h5, 4'hA, 4'hF,
    4'h1, 4'h6, 4'hB, 4'hF, 4'h2, 4'h6, 4'hA, 4'hD, 4'h1, 4'h7, 4'h9, 4'hE,
    4'h3, 4'hD, 4'h9, 4'h5, 4'h2, 4'hE, 4'h9, 4'h4, 4'h2, 4'hE, 4'hB, 4'h7,
    4'h0, 4'hE, 4'h9, 4'h7, 4'h3, 4'hF, 4'hB, 4'h4, 4'h3, 4'hC, 4'h9, 4'h5
  };
  localparam logic [3:0] BANDS_M2 [12] = '{
    4'h2, 4'h7, 4'hA, 4'hE, 4'h1, 4'h6, 4'h8, 4'h6, 4'h2, 4'hD, 4'h8, 4'h7
  };
  localparam logic [3:0] BANDS_M4 [24] = '{
    4'h0, 4'h5, 4'h9, 4'hE, 4'h2, 4'h6, 4'h8, 4'hF, 4'h3, 4'h5, 4'hB, 4'hE,
    4'h0, 4'hD, 4'h8, 4'h6, 4'h0, 4'hD, 4'hA, 4'h6, 4'h2, 4'hD, 4'hB, 4'h4
  };

  // rows of h, period 16
  localparam logic [1:0] HROW [4][16] = '{
    '{2'd0, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1,
      2'd2, 2'd0, 2'd0, 2'd0, 2'd2, 2'd2, 2'd1, 2'd1},
    '{2'd0, 2'd3, 2'd2, 2'd3, 2'd0, 2'd1, 2'd3, 2'd0,
      2'd2, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3, 2'd0},
    '{2'd0, 2'd0, 2'd0, 2'd2, 2'd0, 2'd2, 2'd1, 2'd3,
      2'd2, 2'd2, 2'd0, 2'd2, 2'd2, 2'd0, 2'd1, 2'd3},
    '{2'd0, 2'd1, 2'd2, 2'd1, 2'd0, 2'd3, 2'd3, 2'd2,
      2'd2, 2'd3, 2'd2, 2'd1, 2'd2, 2'd1, 2'd3, 2'd2}
  };

  typedef struct packed {
    logic       valid;
    logic       ok;
    logic [1:0] mode;
    logic [5:0] band;
    logic [3:0] col;
  } dabpr_loc_t;

  typedef struct packed {
    logic       valid;
    logic       ok;
    logic [1:0] row;
    logic [1:0] offs;
    logic [3:0] col;
  } dabpr_ent_t;

endpackage

### design/dabpr_band_locate.sv
module dabpr_band_locate #(
  parameter int HALF_CARRIERS = 768
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic signed [10:0]       k,
  input  logic [1:0]               mode,
  output dabpr_pkg::dabpr_loc_t    loc
);
  import dabpr_pkg::*;

  localparam int LIM_M1 = (HALF_CARRIERS < HALF_M1) ? HALF_CARRIERS : HALF_M1;
  localparam int LIM_M2 = (HALF_CARRIERS < HALF_M2) ? HALF_CARRIERS : HALF_M2;
  localparam int LIM_M4 = (HALF_CARRIERS < HALF_M4) ? HALF_CARRIERS : HALF_M4;

  logic signed [11:0] ks;
  logic signed [11:0] half;
  logic signed [11:0] lim;
  logic [5:0]         base;
  logic               mode_ok;
  logic signed [11:0] off;
  logic               ok;
  logic [5:0]         band;

  assign ks = {k[10], k};

  always_comb begin
    unique case (mode)
      MODE_I: begin
        half = 12'(HALF_M1); lim = 12'(LIM_M1); base = 6'(HALF_M1 / BAND_W);
        mode_ok = 1'b1;
      end
      MODE_II: begin
        half = 12'(HALF_M2); lim = 12'(LIM_M2); base = 6'(HALF_M2 / BAND_W);
        mode_ok = 1'b1;
      end
      MODE_IV: begin
        half = 12'(HALF_M4); lim = 12'(LIM_M4); base = 6'(HALF_M4 / BAND_W);
        mode_ok = 1'b1;
      end
      default: begin
        half = '0; lim = '0; base = '0;
        mode_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    ok  = mode_ok && (ks != 12'sd0) && (ks <= lim) && (ks >= -lim);
    off = ks[11] ? (ks + half) : (ks - 12'sd1);
    band = ks[11] ? {1'b0, off[9:5]} : (base + {1'b0, off[9:5]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loc.valid <= 1'b0;
    end else begin
      loc.valid <= in_valid;
    end
    loc.ok   <= ok;
    loc.mode <= mode;
    loc.band <= band;
    loc.col  <= off[3:0];
  end

endmodule

### design/dabpr_band_lookup.sv
module dabpr_band_lookup (
  input  logic                   clk,
  input  logic                   rst,
  input  dabpr_pkg::dabpr_loc_t  loc,
  output dabpr_pkg::dabpr_ent_t  ent
);
  import dabpr_pkg::*;

  logic [3:0] entry;

  always_comb begin
    unique case (loc.mode)
      MODE_I:  entry = (loc.band < 6'd48) ? BANDS_M1[loc.band] : 4'h0;
      MODE_II: entry = (loc.band < 6'd12) ? BANDS_M2[loc.band[3:0]] : 4'h0;
      MODE_IV: entry = (loc.band < 6'd24) ? BANDS_M4[loc.band[4:0]] : 4'h0;
      default: entry = 4'h0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent.valid <= loc.valid;
    end
    ent.ok   <= loc.ok;
    ent.row  <= entry[3:2];
    ent.offs <= entry[1:0];
    ent.col  <= loc.col;
  end

endmodule

### design/dabpr_phase_map.sv
module dabpr_phase_map (
  input  logic                   clk,
  input  logic                   rst,
  input  dabpr_pkg::dabpr_ent_t  ent,
  output logic                   done,
  output logic [1:0]             phase_quadrant,
  output logic signed [1:0]      ref_real,
  output logic signed [1:0]      ref_imag,
  output logic                   in_band
);
  import dabpr_pkg::*;

  logic [1:0]        q;
  logic signed [1:0] re;
  logic signed [1:0] im;

  always_comb begin
    q = HROW[ent.row][ent.col] + ent.offs;  // wraps mod 4
    unique case (q)
      2'd0:    begin re = 2'sd1;  im = 2'sd0;  end
      2'd1:    begin re = 2'sd0;  im = 2'sd1;  end
      2'd2:    begin re = -2'sd1; im = 2'sd0;  end
      default: begin re = 2'sd0;  im = -2'sd1; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ent.valid;
    end
    phase_quadrant <= ent.ok ? q  : 2'd0;
    ref_real       <= ent.ok ? re : 2'sd0;
    ref_imag       <= ent.ok ? im : 2'sd0;
    in_band        <= ent.ok;
  end

endmodule

### design/dab_phase_reference_gen.sv
// Channel   | Signals                                   | Transfer when
// ----------+-------------------------------------------+----------------------
// command   | start, busy, carrier_index                | start && !busy
// result    | done, phase_quadrant, ref_real, ref_imag, | done (one cycle)
//           | in_band                                   |
// config    | cfg_valid, cfg_ready, cfg_data            | cfg_valid && cfg_ready
//
// One carrier per clock.
// Stages: input register, band locate, band table lookup, phase map.
// rst (synchronous) clears valid bits and sets transmission_mode to mode I.
// busy stays low: the receiver cannot stall, so nothing ever backs up.
module dab_phase_reference_gen #(
  parameter int HALF_CARRIERS = 768
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [10:0] carrier_index,
  output logic               done,
  output logic [1:0]         phase_quadrant,
  output logic signed [1:0]  ref_real,
  output logic signed [1:0]  ref_imag,
  output logic               in_band,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_data
);
  import dabpr_pkg::*;

  logic               s0_valid;
  logic signed [10:0] s0_k;
  logic [1:0]         transmission_mode;
  dabpr_loc_t         loc;
  dabpr_ent_t         ent;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // mode register; the user must write it only while the pipe is empty, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      transmission_mode <= MODE_I;
    end else if (cfg_valid && cfg_ready) begin
      transmission_mode <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
    end
    s0_k <= carrier_index;
  end

  // band index, column and range check
  dabpr_band_locate #(
    .HALF_CARRIERS(HALF_CARRIERS)
  ) u_locate (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s0_valid),
    .k        (s0_k),
    .mode     (transmission_mode),
    .loc      (loc)
  );

  // row i and offset n of the band
  dabpr_band_lookup u_lookup (
    .clk (clk),
    .rst (rst),
    .loc (loc),
    .ent (ent)
  );

  // (h[i][j] + n) mod 4 and the unit value
  dabpr_phase_map u_map (
    .clk            (clk),
    .rst            (rst),
    .ent            (ent),
    .done           (done),
    .phase_quadrant (phase_quadrant),
    .ref_real       (ref_real),
    .ref_imag       (ref_imag),
    .in_band        (in_band)
  );

endmodule

### tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dabpr_pkg::*;

  // The block under test has no name for the fourth register code.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int HALF_CARRIERS = 768;
  // Extra margin after the last result, before mode changes and the end.
  localparam int SETTLE_CYCLES = 10;

  // Expected output of one carrier, at the block's port widths.
  typedef struct packed {
    logic [1:0]        quad;
    logic signed [1:0] re;
    logic signed [1:0] im;
    logic              hit;
  } carrier_ref_t;

  // h rows of the phase reference symbol, each repeating every 16 carriers.
  localparam logic [1:0] H_PHASE [4][16] = '{
    '{2'd0, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1,
      2'd2, 2'd0, 2'd0, 2'd0, 2'd2, 2'd2, 2'd1, 2'd1},
    '{2'd0, 2'd3, 2'd2, 2'd3, 2'd0, 2'd1, 2'd3, 2'd0,
      2'd2, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3, 2'd0},
    '{2'd0, 2'd0, 2'd0, 2'd2, 2'd0, 2'd2, 2'd1, 2'd3,
      2'd2, 2'd2, 2'd0, 2'd2, 2'd2, 2'd0, 2'd1, 2'd3},
    '{2'd0, 2'd1, 2'd2, 2'd1, 2'd0, 2'd3, 2'd3, 2'd2,
      2'd2, 2'd3, 2'd2, 2'd1, 2'd2, 2'd1, 2'd3, 2'd2}
  };

  // Per 32-carrier band, lowest k first: {row, offset}.
  localparam logic [3:0] GRID_M1 [48] = '{
    4'h1, 4'h6, 4'h8, 4'hD, 4'h3, 4'h6, 4'hA, 4'hF, 4'h2, 4'h5, 4'hA, 4'hF,
    4'h1, 4'h6, 4'hB, 4'hF, 4'h2, 4'h6, 4'hA, 4'hD, 4'h1, 4'h7, 4'h9, 4'hE,
    4'h3, 4'hD, 4'h9, 4'h5, 4'h2, 4'hE, 4'h9, 4'h4, 4'h2, 4'hE, 4'hB, 4'h7,
    4'h0, 4'hE, 4'h9, 4'h7, 4'h3, 4'hF, 4'hB, 4'h4, 4'h3, 4'hC, 4'h9, 4'h5
  };
  localparam logic [3:0] GRID_M2 [12] = '{
    4'h2, 4'h7, 4'hA, 4'hE, 4'h1, 4'h6, 4'h8, 4'h6, 4'h2, 4'hD, 4'h8, 4'h7
  };
  localparam logic [3:0] GRID_M4 [24] = '{
    4'h0, 4'h5, 4'h9, 4'hE, 4'h2, 4'h6, 4'h8, 4'hF, 4'h3, 4'h5, 4'hB, 4'hE,
    4'h0, 4'hD, 4'h8, 4'h6, 4'h0, 4'hD, 4'hA, 4'h6, 4'h2, 4'hD, 4'hB, 4'h4
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [10:0] carrier_index = '0;
  logic               done;
  logic [1:0]         phase_quadrant;
  logic signed [1:0]  ref_real;
  logic signed [1:0]  ref_imag;
  logic               in_band;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_data = '0;

  // Testbench copy of transmission_mode, updated on each config transfer.
  logic [1:0]   active_mode = MODE_I;
  carrier_ref_t pending_refs[$];
  int           mismatch_count = 0;
  bit           gaps_on = 1'b1;

  dab_phase_reference_gen #(
    .HALF_CARRIERS(HALF_CARRIERS)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .carrier_index  (carrier_index),
    .done           (done),
    .phase_quadrant (phase_quadrant),
    .ref_real       (ref_real),
    .ref_imag       (ref_imag),
    .in_band        (in_band),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Generous ceiling: ~700 carriers plus settles is far below this.
  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

  function automatic int half_width(input logic [1:0] mode);
    case (mode)
      MODE_I:  half_width = 768;
      MODE_II: half_width = 192;
      MODE_IV: half_width = 384;
      default: half_width = 0;
    endcase
  endfunction

  // Phase reference of carrier k in the given mode.
  function automatic carrier_ref_t phase_ref_of(input logic [1:0] mode,
                                                input logic signed [10:0] k);
    carrier_ref_t r;
    int           kk, half, lim, off, band;
    logic [3:0]   cell_ent;
    logic [1:0]   q;
    r = '0;
    kk = k;
    half = half_width(mode);
    lim = (HALF_CARRIERS < half) ? HALF_CARRIERS : half;
    // Unused mode, DC and anything outside the table: null carrier.
    if (half == 0 || kk == 0 || kk > lim || kk < -lim) return r;
    if (kk < 0) begin
      off = kk + half;
      band = off >> 5;
    end else begin
      off = kk - 1;
      band = half / 32 + (off >> 5);
    end
    case (mode)
      MODE_I:  cell_ent = GRID_M1[band];
      MODE_II: cell_ent = GRID_M2[band];
      default: cell_ent = GRID_M4[band];
    endcase
    q = H_PHASE[cell_ent[3:2]][off[3:0]] + cell_ent[1:0];
    r.quad = q;
    r.re = (q == 2'd0) ? 2'sb01 : (q == 2'd2) ? 2'sb11 : 2'sb00;
    r.im = (q == 2'd1) ? 2'sb01 : (q == 2'd3) ? 2'sb11 : 2'sb00;
    r.hit = 1'b1;
    return r;
  endfunction

  // Result checker and expectation capture, both at the rising edge.
  always @(posedge clk) begin
    carrier_ref_t want;
    if (!rst && done) begin
      if (pending_refs.size() == 0) begin
        $error("result with no pending carrier");
        mismatch_count++;
      end else begin
        want = pending_refs.pop_front();
        if (phase_quadrant !== want.quad) begin
          $error("phase_quadrant: expected %0d, got %0d", want.quad, phase_quadrant);
          mismatch_count++;
        end
        if (ref_real !== want.re) begin
          $error("ref_real: expected %0d, got %0d", want.re, ref_real);
          mismatch_count++;
        end
        if (ref_imag !== want.im) begin
          $error("ref_imag: expected %0d, got %0d", want.im, ref_imag);
          mismatch_count++;
        end
        if (in_band !== want.hit) begin
          $error("in_band: expected %0d, got %0d", want.hit, in_band);
          mismatch_count++;
        end
      end
    end
    // Command transfer: start && !busy.
    if (!rst && start && !busy)
      pending_refs.push_back(phase_ref_of(active_mode, carrier_index));
  end

  // One command transfer. Called right after a falling edge; returns after
  // the next falling edge with start still high, so back-to-back sends keep it up.
  task automatic send_carrier(input logic signed [10:0] k);
    while (gaps_on && $urandom_range(99) < 7) begin
      start <= 1'b0;
      carrier_index <= 11'($urandom_range(2047));
      @(negedge clk);
    end
    start <= 1'b1;
    carrier_index <= k;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Drop start and wait until every pending result has come, plus the pipeline tail.
  task automatic settle();
    start <= 1'b0;
    while (pending_refs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mode change, only with the pipeline empty.
  task automatic write_mode(input logic [1:0] mode);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    do @(posedge clk); while (!cfg_ready);
    active_mode = mode;
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data <= 2'($urandom_range(3));
  endtask

  function automatic logic signed [10:0] pick_carrier(input logic [1:0] mode);
    int half;
    half = half_width(mode);
    // Mostly carriers inside the active table, the rest anywhere in 11 bits.
    if (half != 0 && $urandom_range(99) < 80)
      return 11'(int'($urandom_range(2 * half)) - half);
    return 11'($urandom_range(2047));
  endfunction

  // Default mode after reset: band edges, DC, table edge, field extremes.
  task automatic test_reset_mode_i();
    logic signed [10:0] probes[$];
    probes = '{-11'sd768, -11'sd737, -11'sd736, -11'sd1, 11'sd0, 11'sd1, 11'sd32,
               11'sd33, 11'sd768, 11'sd769, -11'sd769, 11'sd1023, -11'sd1024};
    foreach (probes[p]) send_carrier(probes[p]);
    settle();
  endtask

  // Modes II and IV at their table edges, then the unused mode.
  task automatic test_other_modes();
    logic signed [10:0] probes_m2[$];
    logic signed [10:0] probes_m4[$];
    logic signed [10:0] probes_none[$];
    probes_m2 = '{-11'sd192, -11'sd193, 11'sd192, 11'sd193, -11'sd1, 11'sd97};
    probes_m4 = '{-11'sd384, -11'sd385, 11'sd384, 11'sd385};
    probes_none = '{11'sd0, 11'sd1, -11'sd768, 11'sd768};
    write_mode(MODE_II);
    foreach (probes_m2[p]) send_carrier(probes_m2[p]);
    write_mode(MODE_IV);
    foreach (probes_m4[p]) send_carrier(probes_m4[p]);
    write_mode(MODE_UNUSED);
    foreach (probes_none[p]) send_carrier(probes_none[p]);
    settle();
  endtask

  // Random carriers in rounds, one mode per round; first round has no gaps.
  task automatic test_random_carriers();
    logic [1:0] round_modes[4];
    logic [1:0] mode;
    round_modes = '{MODE_I, MODE_IV, MODE_II, MODE_UNUSED};
    for (int rnd = 0; rnd < 8; rnd++) begin
      mode = (rnd < 4) ? round_modes[rnd] : 2'($urandom_range(3));
      write_mode(mode);
      gaps_on = (rnd != 0);
      for (int n = 0; n < 75; n++) begin
        // Sender holds off mid-round until the pipeline has emptied.
        if (rnd == 2 && n == 40) settle();
        send_carrier(pick_carrier(mode));
      end
    end
    gaps_on = 1'b1;
    write_mode(MODE_I);
    settle();
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_mode_i();
    test_other_modes();
    test_random_carriers();
    settle();
    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
